FILE: hw/rtl/shs_pkg.sv
// ----------------------------------------------------------------------------
// shs_pkg
// Shared types and constants for the streaming SHA-256 hasher.
// ----------------------------------------------------------------------------
package shs_pkg;

	localparam logic [31:0] IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [7:0]  PAD_MARK  = 8'h80;
	localparam logic [5:0]  LEN_START = 6'd56;

	// commands from the sequencer to the compression core
	typedef struct packed {
		logic         push;
		logic [7:0]   push_byte;
		logic         load;
		logic [511:0] blk;
		logic         start;
		logic         iv;
	} shs_cmd_t;

	function automatic logic [31:0] round_k(input logic [5:0] t);
		logic [31:0] k;
		unique case (t)
			6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
			6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
			6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
			6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
			6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
			6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
			6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
			6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
			6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
			6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
			6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
			6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
			6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
			6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
			6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
			6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
			6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
			6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
			6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
			6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
			6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
			6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
			6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
			default: k = 32'h0;
		endcase
		return k;
	endfunction

endpackage

FILE: hw/rtl/shs_core.sv
// ----------------------------------------------------------------------------
// shs_core
// Block window, message schedule and one SHA-256 round per cycle, with the
// chain value and its final add.
// ----------------------------------------------------------------------------
module shs_core import shs_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  shs_cmd_t       cmd,
	output logic           done,
	output logic [255:0]   chain
);

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

	logic [511:0] win_q;
	logic [31:0]  v_q [8];
	logic [31:0]  chain_q [8];
	logic [5:0]   rnd_q;
	logic         run_q;
	logic         fin_q;

	logic [31:0] w0, w1, w9, w14, s0, s1, w_new;
	logic [31:0] sig0, sig1, ch, maj, t1, t2;

	// the oldest schedule word sits at the top of the window
	assign w0  = win_q[511:480];
	assign w1  = win_q[479:448];
	assign w9  = win_q[223:192];
	assign w14 = win_q[63:32];

	always_comb begin
		s0    = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
		s1    = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
		w_new = s1 + w9 + s0 + w0;
		sig1  = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
		sig0  = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
		ch    = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		maj   = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t1    = v_q[7] + sig1 + ch + round_k(rnd_q) + w0;
		t2    = sig0 + maj;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			win_q <= cmd.blk;
		end else if (cmd.push) begin
			win_q <= {win_q[503:0], cmd.push_byte};
		end else if (run_q) begin
			win_q <= {win_q[479:0], w_new};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			for (int i = 0; i < 8; i++) begin
				v_q[i] <= cmd.iv ? IV[i] : chain_q[i];
			end
		end else if (run_q) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				chain_q[i] <= IV[i];
			end
			rnd_q <= '0;
			run_q <= 1'b0;
			fin_q <= 1'b0;
		end else begin
			fin_q <= 1'b0;
			if (cmd.iv) begin
				for (int i = 0; i < 8; i++) begin
					chain_q[i] <= IV[i];
				end
			end else if (fin_q) begin
				for (int i = 0; i < 8; i++) begin
					chain_q[i] <= chain_q[i] + v_q[i];
				end
			end
			if (cmd.start) begin
				run_q <= 1'b1;
				rnd_q <= '0;
			end else if (run_q) begin
				rnd_q <= rnd_q + 6'd1;
				if (rnd_q == 6'd63) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end
		end
	end

	assign done = fin_q;

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			chain[255 - 32*i -: 32] = chain_q[i];
		end
	end

endmodule

FILE: hw/rtl/sha256_stream_hasher.sv
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// Streaming SHA-256 with optional double hashing and a four-word digest drain.
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle while input ready is high. The byte that
// completes a 64-byte block starts a compression of 64 rounds, one round a
// cycle in a single round unit, followed by the chain add; input ready stays
// low meanwhile. At message end the sequencer writes padding one byte a
// cycle up to the end of the block and compresses it; when the tail leaves
// fewer than 9 bytes, another block of padding and a second compression
// follow. double_hash adds one more compression, and publishing the digest
// waits while the previous digest still drains. The digest goes to an
// output buffer and drains as four words while new bytes are accepted.
module sha256_stream_hasher import shs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write_en,
	input  logic        cfg_write_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  byte_value,
	input  logic        byte_valid,
	input  logic        message_end,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] digest_word,
	output logic [1:0]  word_index,
	output logic        last_word
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_COMP = 3'd1;
	localparam logic [2:0] ST_PAD  = 3'd2;
	localparam logic [2:0] ST_FIN  = 3'd3;
	localparam logic [2:0] ST_PUB  = 3'd4;

	logic [2:0]   state_q, ret_q;
	logic [5:0]   fill_q;
	logic [63:0]  bits_q;
	logic         mark_q, wrap_q, dbl_q, double_hash_q;
	logic [255:0] out_q;
	logic [2:0]   out_cnt_q;
	logic [1:0]   idx_q;

	shs_cmd_t     cmd;
	logic         core_done;
	logic [255:0] chain;
	logic         acc, len_phase, last_slot;

	shs_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.done   (core_done),
		.chain  (chain)
	);

	assign in_ready  = (state_q == ST_IDLE);
	assign acc       = in_valid && in_ready;
	assign len_phase = mark_q && !wrap_q && (fill_q >= LEN_START);
	assign last_slot = (fill_q == 6'd63);

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (acc && byte_valid) begin
					cmd.push      = 1'b1;
					cmd.push_byte = byte_value;
					cmd.start     = last_slot;
				end
			end
			ST_PAD: begin
				cmd.push = 1'b1;
				if (!mark_q) begin
					cmd.push_byte = PAD_MARK;
				end else if (len_phase) begin
					cmd.push_byte = bits_q[{3'd7 - fill_q[2:0], 3'b000} +: 8];
				end else begin
					cmd.push_byte = 8'h00;
				end
				cmd.start = last_slot;
			end
			ST_FIN: begin
				if (double_hash_q && !dbl_q) begin
					cmd.load  = 1'b1;
					cmd.blk   = {chain, 32'h8000_0000, 160'h0, 64'd256};
					cmd.start = 1'b1;
					cmd.iv    = 1'b1;
				end
			end
			ST_PUB: begin
				cmd.iv = (out_cnt_q == 3'd0);
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			ret_q         <= ST_IDLE;
			fill_q        <= '0;
			bits_q        <= '0;
			mark_q        <= 1'b0;
			wrap_q        <= 1'b0;
			dbl_q         <= 1'b0;
			double_hash_q <= 1'b0;
			out_cnt_q     <= '0;
			idx_q         <= '0;
		end else begin
			if (cfg_write_en) begin
				double_hash_q <= cfg_write_data;
			end
			if (out_valid && out_ready) begin
				out_cnt_q <= out_cnt_q - 3'd1;
				idx_q     <= idx_q + 2'd1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						if (byte_valid) begin
							fill_q <= fill_q + 6'd1;
							bits_q <= bits_q + 64'd8;
							if (last_slot) begin
								state_q <= ST_COMP;
								ret_q   <= message_end ? ST_PAD : ST_IDLE;
							end else if (message_end) begin
								state_q <= ST_PAD;
							end
						end else if (message_end) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_COMP: begin
					if (core_done) begin
						state_q <= ret_q;
					end
				end
				ST_PAD: begin
					fill_q <= fill_q + 6'd1;
					if (!mark_q) begin
						mark_q <= 1'b1;
						// length must wait for a fresh block
						wrap_q <= (fill_q >= LEN_START) && !last_slot;
					end
					if (last_slot) begin
						state_q <= ST_COMP;
						ret_q   <= len_phase ? ST_FIN : ST_PAD;
						if (mark_q) begin
							wrap_q <= 1'b0;
						end
					end
				end
				ST_FIN: begin
					if (double_hash_q && !dbl_q) begin
						dbl_q   <= 1'b1;
						state_q <= ST_COMP;
						ret_q   <= ST_FIN;
					end else begin
						state_q <= ST_PUB;
					end
				end
				ST_PUB: begin
					// hold until the previous digest has drained
					if (out_cnt_q == 3'd0) begin
						out_cnt_q <= 3'd4;
						idx_q     <= '0;
						fill_q    <= '0;
						bits_q    <= '0;
						mark_q    <= 1'b0;
						wrap_q    <= 1'b0;
						dbl_q     <= 1'b0;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_PUB && out_cnt_q == 3'd0) begin
			out_q <= chain;
		end else if (out_valid && out_ready) begin
			out_q <= {out_q[191:0], 64'h0};
		end
	end

	assign out_valid   = (out_cnt_q != 3'd0);
	assign digest_word = out_q[255:192];
	assign word_index  = idx_q;
	assign last_word   = (idx_q == 2'd3);

endmodule

FILE: hw/rtl/shs_checker.sv
// ----------------------------------------------------------------------------
// shs_checker
// Port-level checks on the digest output of the hasher, bound to the top.
// ----------------------------------------------------------------------------
module shs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] digest_word,
	input logic [1:0]  word_index,
	input logic        last_word
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(digest_word) && $stable(word_index))
		else $error("output word changed while stalled");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_word == (word_index == 2'd3)))
		else $error("last_word does not match word_index");

	a_next: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_word |=>
			out_valid && (word_index == $past(word_index) + 2'd1))
		else $error("digest words not contiguous");

	a_first: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last_word |=> !out_valid || (word_index == 2'd0))
		else $error("new digest does not start at word 0");

endmodule

bind sha256_stream_hasher shs_checker u_shs_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.digest_word (digest_word),
	.word_index  (word_index),
	.last_word   (last_word)
);
